/* rtl/iirdf1_pkg.sv */
// types, constants and codes shared by the direct form one filter modules
`default_nettype none

package iirdf1_pkg;

   // sample and coefficient formats (coefficients are Q2.14)
   localparam int SAMPLE_BITS    = 16;
   localparam int COEF_BITS      = 16;
   localparam int HIST_DEPTH     = 3;
   localparam int CSR_INDEX_BITS = 3;

   // datapath widths: seven tap products of at most 2^30 fit in the accumulator
   localparam int ACC_BITS    = SAMPLE_BITS + COEF_BITS + 2;
   localparam int LO_BITS     = 17;
   localparam int HI_BITS     = ACC_BITS - LO_BITS;
   localparam int MUL_A_BITS  = 18;
   localparam int PROD_BITS   = MUL_A_BITS + COEF_BITS;
   localparam int SCALE_BITS  = ACC_BITS + COEF_BITS;
   localparam int FRAC_SHIFT  = 28;
   localparam int RESULT_BITS = SCALE_BITS - FRAC_SHIFT;

   // output range
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   // register reset values
   localparam logic signed [COEF_BITS-1:0] COEF_ONE  = 16'sd16384;
   localparam logic signed [COEF_BITS-1:0] COEF_ZERO = 16'sd0;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_B0  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_B1  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_B2  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_B3  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_A1  = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_A2  = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_A3  = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] REG_INV = 3'd7;

   // multiplier operand selection
   localparam logic [1:0] MUL_FF = 2'd0;
   localparam logic [1:0] MUL_FB = 2'd1;
   localparam logic [1:0] MUL_HI = 2'd2;
   localparam logic [1:0] MUL_LO = 2'd3;

   // operation applied to the registered product in the cycle after the multiply
   localparam logic [2:0] ACC_NONE     = 3'd0;
   localparam logic [2:0] ACC_ADD      = 3'd1;
   localparam logic [2:0] ACC_SUB      = 3'd2;
   localparam logic [2:0] ACC_SCALE_HI = 3'd3;
   localparam logic [2:0] ACC_SCALE_LO = 3'd4;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_in;
      logic                          block_start;
   } iirdf1_req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_out;
      logic                          saturated;
   } iirdf1_rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic       load;
      logic [1:0] mul_kind;
      logic [1:0] mul_idx;
      logic [2:0] acc_op;
      logic       finish;
   } iirdf1_cmd_type;

endpackage

`default_nettype wire

/* rtl/iirdf1_ctrl.sv */
// sequencer that steps the shared multiplier through taps and scaling
`default_nettype none

module iirdf1_ctrl
   import iirdf1_pkg::*;
#(
   parameter int FF_TAPS = 4,
   parameter int FB_TAPS = 3
) (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  wire logic   rsp_ready,
   output iirdf1_cmd_type cmd
);

   localparam int TAP_COUNT = FF_TAPS + FB_TAPS;
   localparam int STEP_BITS = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_TAPS  = 3'd1;
   localparam logic [2:0] ST_DRAIN = 3'd2;
   localparam logic [2:0] ST_HI    = 3'd3;
   localparam logic [2:0] ST_LO    = 3'd4;
   localparam logic [2:0] ST_FLUSH = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   logic [2:0]           state_ff, state_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [2:0]           step_wide;
   logic                 out_free;
   logic                 req_fire;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign step_wide = 3'(step_ff);

   // next state and command decode
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.mul_kind = MUL_FF;
      cmd.acc_op   = ACC_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cmd.load = 1'b1;
               step_in  = '0;
               state_in = ST_TAPS;
            end
         end
         ST_TAPS: begin
            if (step_wide < 3'(FF_TAPS)) begin
               cmd.mul_kind = MUL_FF;
               cmd.mul_idx  = step_wide[1:0];
               cmd.acc_op   = ACC_ADD;
            end else begin
               cmd.mul_kind = MUL_FB;
               cmd.mul_idx  = 2'(step_wide - 3'(FF_TAPS) + 3'd1);
               cmd.acc_op   = ACC_SUB;
            end
            if (step_ff == STEP_BITS'(TAP_COUNT - 1)) begin
               state_in = ST_DRAIN;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_HI;
         end
         ST_HI: begin
            cmd.mul_kind = MUL_HI;
            cmd.acc_op   = ACC_SCALE_HI;
            state_in     = ST_LO;
         end
         ST_LO: begin
            cmd.mul_kind = MUL_LO;
            cmd.acc_op   = ACC_SCALE_LO;
            state_in     = ST_FLUSH;
         end
         ST_FLUSH: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // result goes out once the output register is free
            if (out_free) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/iirdf1_datapath.sv */
// coefficient registers, histories, shared multiplier, accumulators and output register
`default_nettype none

module iirdf1_datapath
   import iirdf1_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire iirdf1_req_type                req_data,
   input  wire iirdf1_cmd_type                cmd,
   input  wire logic                          csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  wire logic signed [COEF_BITS-1:0]   csr_wdata,
   output iirdf1_rsp_type                     rsp_data
);

   logic signed [COEF_BITS-1:0]   coef_b_ff [4];
   logic signed [COEF_BITS-1:0]   coef_a_ff [3];
   logic signed [COEF_BITS-1:0]   inv_ff;
   logic signed [SAMPLE_BITS-1:0] x0_ff;
   logic signed [SAMPLE_BITS-1:0] x_hist_ff [HIST_DEPTH];
   logic signed [SAMPLE_BITS-1:0] y_hist_ff [HIST_DEPTH];
   logic signed [ACC_BITS-1:0]    acc_ff;
   logic signed [SCALE_BITS-1:0]  scale_ff;
   logic signed [PROD_BITS-1:0]   prod_ff, prod_in;
   logic [2:0]                    op_ff;
   iirdf1_rsp_type                rsp_data_ff, rsp_data_in;

   logic signed [MUL_A_BITS-1:0]  mul_a;
   logic signed [COEF_BITS-1:0]   mul_b;
   logic signed [SCALE_BITS-1:0]  rounded;
   logic signed [RESULT_BITS-1:0] y_wide;

   assign rsp_data = rsp_data_ff;

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.mul_kind)
         MUL_FF: begin
            case (cmd.mul_idx)
               2'd0:    mul_a = MUL_A_BITS'(x0_ff);
               2'd1:    mul_a = MUL_A_BITS'(x_hist_ff[0]);
               2'd2:    mul_a = MUL_A_BITS'(x_hist_ff[1]);
               default: mul_a = MUL_A_BITS'(x_hist_ff[2]);
            endcase
            mul_b = coef_b_ff[cmd.mul_idx];
         end
         MUL_FB: begin
            case (cmd.mul_idx)
               2'd1: begin
                  mul_a = MUL_A_BITS'(y_hist_ff[0]);
                  mul_b = coef_a_ff[0];
               end
               2'd2: begin
                  mul_a = MUL_A_BITS'(y_hist_ff[1]);
                  mul_b = coef_a_ff[1];
               end
               2'd3: begin
                  mul_a = MUL_A_BITS'(y_hist_ff[2]);
                  mul_b = coef_a_ff[2];
               end
               default: begin
                  mul_a = '0;
                  mul_b = '0;
               end
            endcase
         end
         MUL_HI: begin
            mul_a = MUL_A_BITS'($signed(acc_ff[ACC_BITS-1:LO_BITS]));
            mul_b = inv_ff;
         end
         default: begin
            mul_a = MUL_A_BITS'({1'b0, acc_ff[LO_BITS-1:0]});
            mul_b = inv_ff;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // round half up, then clip to the sample range
   assign rounded = scale_ff + (SCALE_BITS'(1) <<< (FRAC_SHIFT - 1));
   assign y_wide  = $signed(rounded[SCALE_BITS-1:FRAC_SHIFT]);

   always_comb begin
      if (y_wide > RESULT_BITS'(SAMPLE_MAX)) begin
         rsp_data_in.sample_out = SAMPLE_MAX;
         rsp_data_in.saturated  = 1'b1;
      end else if (y_wide < RESULT_BITS'(SAMPLE_MIN)) begin
         rsp_data_in.sample_out = SAMPLE_MIN;
         rsp_data_in.saturated  = 1'b1;
      end else begin
         rsp_data_in.sample_out = y_wide[SAMPLE_BITS-1:0];
         rsp_data_in.saturated  = 1'b0;
      end
   end

   // product register, and accumulation of the registered product in the cycle after the multiply
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      case (op_ff)
         ACC_ADD:      acc_ff   <= acc_ff + ACC_BITS'(prod_ff);
         ACC_SUB:      acc_ff   <= acc_ff - ACC_BITS'(prod_ff);
         ACC_SCALE_HI: scale_ff <= SCALE_BITS'(prod_ff) <<< LO_BITS;
         ACC_SCALE_LO: scale_ff <= scale_ff + SCALE_BITS'(prod_ff);
         default: begin
         end
      endcase
      if (cmd.load) begin
         acc_ff <= '0;
         x0_ff  <= req_data.sample_in;
      end
      if (cmd.finish) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // delayed accumulate operation
   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff <= ACC_NONE;
      end else begin
         op_ff <= cmd.acc_op;
      end
   end

   // input and output histories
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HIST_DEPTH; i++) begin
            x_hist_ff[i] <= '0;
            y_hist_ff[i] <= '0;
         end
      end else if (cmd.load && req_data.block_start) begin
         for (int i = 0; i < HIST_DEPTH; i++) begin
            x_hist_ff[i] <= '0;
            y_hist_ff[i] <= '0;
         end
      end else if (cmd.finish) begin
         for (int i = HIST_DEPTH - 1; i > 0; i--) begin
            x_hist_ff[i] <= x_hist_ff[i-1];
            y_hist_ff[i] <= y_hist_ff[i-1];
         end
         x_hist_ff[0] <= x0_ff;
         y_hist_ff[0] <= rsp_data_in.sample_out;
      end
   end

   // coefficient registers
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_b_ff[0] <= COEF_ONE;
         coef_b_ff[1] <= COEF_ZERO;
         coef_b_ff[2] <= COEF_ZERO;
         coef_b_ff[3] <= COEF_ZERO;
         coef_a_ff[0] <= COEF_ZERO;
         coef_a_ff[1] <= COEF_ZERO;
         coef_a_ff[2] <= COEF_ZERO;
         inv_ff       <= COEF_ONE;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_B0:  coef_b_ff[0] <= csr_wdata;
            REG_B1:  coef_b_ff[1] <= csr_wdata;
            REG_B2:  coef_b_ff[2] <= csr_wdata;
            REG_B3:  coef_b_ff[3] <= csr_wdata;
            REG_A1:  coef_a_ff[0] <= csr_wdata;
            REG_A2:  coef_a_ff[1] <= csr_wdata;
            REG_A3:  coef_a_ff[2] <= csr_wdata;
            REG_INV: inv_ff       <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

endmodule

`default_nettype wire

/* rtl/iir_direct_form_one.sv */
// top level of the direct form one iir filter
`default_nettype none

// Direct form I IIR filter, order up to three, Q2.14 coefficients, one output
// request per input request. Samples are processed one at a time: a request is
// taken while idle, then a single shared 18x16 multiplier with a registered
// product steps through the FF_TAPS + FB_TAPS taps, a drain state, the split
// multiply of the accumulator high and low halves by the inv register, a flush
// state and the round/saturate state, which waits until the output register is
// free. The result sits in an output register and the next request is taken
// while it waits. Coefficients are written through the csr port; the user must
// write them only while the filter is idle, which the block does not enforce;
// block_start clears both histories before its sample is used.

module iir_direct_form_one
   import iirdf1_pkg::*;
#(
   parameter int FF_TAPS = 4,
   parameter int FB_TAPS = 3
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire iirdf1_req_type              req_data,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output iirdf1_rsp_type                   rsp_data,
   input  wire logic                        csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic signed [COEF_BITS-1:0] csr_wdata
);

   iirdf1_cmd_type cmd;

   // sequencer
   iirdf1_ctrl #(
      .FF_TAPS (FF_TAPS),
      .FB_TAPS (FB_TAPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // arithmetic and storage
   iirdf1_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

/* rtl/iirdf1_checker.sv */
// port level checks for the direct form one filter and their bind
`default_nettype none

module iirdf1_port_checks
   import iirdf1_pkg::*;
(
   input wire logic           clock,
   input wire logic           reset,
   input wire logic           req_valid,
   input wire logic           req_ready,
   input wire logic           rsp_valid,
   input wire logic           rsp_ready,
   input wire iirdf1_rsp_type rsp_data
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or dropped");

   // one request at a time: busy right after a request
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // no result can appear in the cycle after a request
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("result appeared too early");

   // a clipped result is at the range limit
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.saturated |->
         (rsp_data.sample_out == SAMPLE_MAX) || (rsp_data.sample_out == SAMPLE_MIN))
      else $error("saturated result not at range limit");

endmodule

bind iir_direct_form_one iirdf1_port_checks u_checker (.*);

`default_nettype wire
